### rtl/rhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants for the RGB hue step unit
// Stream widths, chroma sector codes, divider state and reciprocal constants.
// ----------------------------------------------------------------------------
package rhs_pkg;

    localparam int CH_W    = 8;                       // one color channel
    localparam int HUE_W   = 9;                       // hue in whole degrees
    localparam int IN_W    = 3 * CH_W;                // packed input fields
    localparam int OUT_RAW = 3 * CH_W + HUE_W;        // packed output fields
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8; // padded to whole bytes

    // Hue numerator 2*num + 3*d stays below 723*255, so 18 bits hold it.
    localparam int NUM_W   = 18;
    localparam int DIV_W   = 9;                       // divisor 2*d and quotient
    localparam int DIV_STG = 3;                       // pipeline stages of the divider
    localparam int DIV_BPS = DIV_W / DIV_STG;         // quotient bits per stage

    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
    localparam logic [HUE_W-1:0] HUE_GRAY = 9'd1;

    // floor(x / 60) = (x * RECIP_60) >> RECIP_SH for every x below 74898.
    localparam logic [16:0] RECIP_60 = 17'd69906;
    localparam int          RECIP_SH = 22;
    localparam int          PROD_W   = 31;

    // Which channel holds the maximum; ties go to red, then green.
    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_max_sel;

    // Sixty-degree hue sector.
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // Running state of the restoring divider.
    typedef struct packed {
        logic [DIV_W-1:0] rem;   // partial remainder, below the divisor unless that is zero
        logic [DIV_W-1:0] nlo;   // dividend bits not yet shifted in
        logic [DIV_W-1:0] quo;   // quotient bits produced so far
    } t_div;

    // Advances the restoring division by DIV_BPS quotient bits.
    function automatic t_div div_step(input t_div x, input logic [DIV_W-1:0] dv);
        t_div           y;
        logic [DIV_W:0] rr;
        y = x;
        for (int k = 0; k < DIV_BPS; k++) begin
            rr = {y.rem, y.nlo[DIV_W-1]};
            y.nlo = {y.nlo[DIV_W-2:0], 1'b0};
            if (rr >= {1'b0, dv}) begin
                rr    = rr - {1'b0, dv};
                y.quo = {y.quo[DIV_W-2:0], 1'b1};
            end else begin
                y.quo = {y.quo[DIV_W-2:0], 1'b0};
            end
            y.rem = rr[DIV_W-1:0];
        end
        return y;
    endfunction

endpackage

### rtl/rgb_hue_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hue_step_unit: one-degree HSV hue rotation of an 8-bit RGB color
// Throughput: one color per cycle while the output is not stalled; the nine-stage pipe,
// with the hue divider spread over three of its stages, then takes a new color each cycle.
// Reset (i_rst_n low, synchronous) empties the pipe; no result is pending after it.
// ----------------------------------------------------------------------------
module rgb_hue_step_unit
    import rhs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    // Output stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // red_out[7:0], green_out[15:8],
                                               // blue_out[23:16], hue_out[32:24], zeros
);

    // Pipe stages, in order:
    //   0      max, min, chroma d and the signed channel difference
    //   1      hue numerator N = 2*num + 3*d, with num wrapped into [0, 360*d)
    //   2..4   restoring division N / (2*d), three quotient bits per stage
    //   5      wrap at 360, gray override, sector and ramp weight
    //   6      d * weight
    //   7      multiply by the reciprocal of 60
    //   8      channel assembly into the output register
    // Every stage has its own valid bit and may load whenever it is empty or
    // the stage after it moves, so bubbles close up under back pressure.
    localparam int NSTG = 9;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_s_axis_tready = stg_en[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: find the largest and smallest channel. Red wins a tie for
    // the maximum, then green. The difference term follows the winner.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] in_r, in_g, in_b;
    logic [CH_W-1:0] n_s0_mx, n_s0_mn;
    t_max_sel        n_s0_sel;
    logic [CH_W:0]   n_s0_diff;

    assign in_r = i_s_axis_tdata[CH_W-1:0];
    assign in_g = i_s_axis_tdata[2*CH_W-1:CH_W];
    assign in_b = i_s_axis_tdata[3*CH_W-1:2*CH_W];

    always_comb begin
        priority if (in_r >= in_g && in_r >= in_b) begin
            n_s0_sel  = MAX_RED;
            n_s0_mx   = in_r;
            n_s0_diff = {1'b0, in_g} - {1'b0, in_b};
        end else if (in_g >= in_b) begin
            n_s0_sel  = MAX_GREEN;
            n_s0_mx   = in_g;
            n_s0_diff = {1'b0, in_b} - {1'b0, in_r};
        end else begin
            n_s0_sel  = MAX_BLUE;
            n_s0_mx   = in_b;
            n_s0_diff = {1'b0, in_r} - {1'b0, in_g};
        end
        n_s0_mn = in_r;
        if (in_g < n_s0_mn) begin
            n_s0_mn = in_g;
        end
        if (in_b < n_s0_mn) begin
            n_s0_mn = in_b;
        end
    end

    logic [CH_W-1:0] r_s0_mn, r_s0_d;
    t_max_sel        r_s0_sel;
    logic [CH_W:0]   r_s0_diff;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s0_mn   <= n_s0_mn;
            r_s0_d    <= n_s0_mx - n_s0_mn;
            r_s0_sel  <= n_s0_sel;
            r_s0_diff <= n_s0_diff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the hue in degrees is num/d with num = 60*diff + offset*d.
    // A negative num is wrapped by 360*d. The dividend folds in the one
    // degree step and the half for rounding: N = 2*num + 3*d.
    // ------------------------------------------------------------------
    logic signed [19:0] s1_d, s1_diff, s1_num, s1_n;

    always_comb begin
        s1_d    = signed'({12'b0, r_s0_d});
        s1_diff = signed'({{11{r_s0_diff[CH_W]}}, r_s0_diff});
        s1_num  = s1_diff * 20'sd60;
        unique case (r_s0_sel)
            MAX_GREEN: s1_num = s1_num + s1_d * 20'sd120;
            MAX_BLUE:  s1_num = s1_num + s1_d * 20'sd240;
            default:   s1_num = s1_num;
        endcase
        if (s1_num < 0) begin
            s1_num = s1_num + s1_d * 20'sd360;
        end
        s1_n = s1_num * 20'sd2 + s1_d * 20'sd3;
    end

    logic [NUM_W-1:0] r_s1_n;
    logic [CH_W-1:0]  r_s1_mn, r_s1_d;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s1_n  <= s1_n[NUM_W-1:0];
            r_s1_mn <= r_s0_mn;
            r_s1_d  <= r_s0_d;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: N / (2*d). The quotient stays below 362, so the upper
    // nine dividend bits already sit below the divisor and seed the
    // remainder; the lower nine bits are shifted in over three stages.
    // A gray input has d = 0 and its quotient is replaced in stage 5.
    // ------------------------------------------------------------------
    t_div            div_init;
    t_div            r_dv [DIV_STG];
    logic [CH_W-1:0] r_dd [DIV_STG];
    logic [CH_W-1:0] r_dmn[DIV_STG];

    always_comb begin
        div_init.rem = r_s1_n[NUM_W-1:DIV_W];
        div_init.nlo = r_s1_n[DIV_W-1:0];
        div_init.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_dv[0]  <= div_step(div_init, {r_s1_d, 1'b0});
            r_dd[0]  <= r_s1_d;
            r_dmn[0] <= r_s1_mn;
        end
        for (int k = 1; k < DIV_STG; k++) begin
            if (stg_en[2+k]) begin
                r_dv[k]  <= div_step(r_dv[k-1], {r_dd[k-1], 1'b0});
                r_dd[k]  <= r_dd[k-1];
                r_dmn[k] <= r_dmn[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: wrap the new hue at 360 and force a gray input to hue 1.
    // The ramp weight is 60 - |H mod 120 - 60|, and the sector is H / 60.
    // ------------------------------------------------------------------
    logic [HUE_W-1:0] s5_hue;
    logic [6:0]       s5_m120;
    logic [5:0]       s5_wt;
    t_sector          s5_sec;

    always_comb begin
        if (r_dd[DIV_STG-1] == '0) begin
            s5_hue = HUE_GRAY;
        end else if (r_dv[DIV_STG-1].quo >= HUE_FULL) begin
            s5_hue = r_dv[DIV_STG-1].quo - HUE_FULL;
        end else begin
            s5_hue = r_dv[DIV_STG-1].quo;
        end

        priority if (s5_hue >= 9'd240) begin
            s5_m120 = 7'(s5_hue - 9'd240);
        end else if (s5_hue >= 9'd120) begin
            s5_m120 = 7'(s5_hue - 9'd120);
        end else begin
            s5_m120 = s5_hue[6:0];
        end

        // Distance from the sector pair's center, turned into a weight.
        if (s5_m120 >= 7'd60) begin
            s5_wt = 6'(7'd120 - s5_m120);
        end else begin
            s5_wt = s5_m120[5:0];
        end

        priority if (s5_hue >= 9'd300) begin
            s5_sec = SEC_5;
        end else if (s5_hue >= 9'd240) begin
            s5_sec = SEC_4;
        end else if (s5_hue >= 9'd180) begin
            s5_sec = SEC_3;
        end else if (s5_hue >= 9'd120) begin
            s5_sec = SEC_2;
        end else if (s5_hue >= 9'd60) begin
            s5_sec = SEC_1;
        end else begin
            s5_sec = SEC_0;
        end
    end

    logic [HUE_W-1:0] r_s5_hue;
    t_sector          r_s5_sec;
    logic [5:0]       r_s5_wt;
    logic [CH_W-1:0]  r_s5_d, r_s5_mn;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s5_hue <= s5_hue;
            r_s5_sec <= s5_sec;
            r_s5_wt  <= s5_wt;
            r_s5_d   <= r_dd[DIV_STG-1];
            r_s5_mn  <= r_dmn[DIV_STG-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: f = floor(d * weight / 60). The product stays below
    // 15301, well inside the range where the reciprocal is exact.
    // ------------------------------------------------------------------
    logic [13:0]      r_s6_x;
    logic [HUE_W-1:0] r_s6_hue;
    t_sector          r_s6_sec;
    logic [CH_W-1:0]  r_s6_d, r_s6_mn;

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_s6_x   <= 14'(r_s5_d * r_s5_wt);
            r_s6_hue <= r_s5_hue;
            r_s6_sec <= r_s5_sec;
            r_s6_d   <= r_s5_d;
            r_s6_mn  <= r_s5_mn;
        end
    end

    logic [PROD_W-1:0] r_s7_p;
    logic [HUE_W-1:0]  r_s7_hue;
    t_sector           r_s7_sec;
    logic [CH_W-1:0]   r_s7_d, r_s7_mn;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_s7_p   <= PROD_W'(r_s6_x * RECIP_60);
            r_s7_hue <= r_s6_hue;
            r_s7_sec <= r_s6_sec;
            r_s7_d   <= r_s6_d;
            r_s7_mn  <= r_s6_mn;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: place chroma and ramp per sector and lift by the minimum.
    // No channel can pass the original maximum, so the sums fit 8 bits.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] s8_f;
    logic [CH_W-1:0] s8_cr, s8_cg, s8_cb;

    always_comb begin
        s8_f = r_s7_p[RECIP_SH+CH_W-1:RECIP_SH];
        unique case (r_s7_sec)
            SEC_0: begin
                s8_cr = r_s7_d; s8_cg = s8_f;   s8_cb = '0;
            end
            SEC_1: begin
                s8_cr = s8_f;   s8_cg = r_s7_d; s8_cb = '0;
            end
            SEC_2: begin
                s8_cr = '0;     s8_cg = r_s7_d; s8_cb = s8_f;
            end
            SEC_3: begin
                s8_cr = '0;     s8_cg = s8_f;   s8_cb = r_s7_d;
            end
            SEC_4: begin
                s8_cr = s8_f;   s8_cg = '0;     s8_cb = r_s7_d;
            end
            default: begin
                s8_cr = r_s7_d; s8_cg = '0;     s8_cb = s8_f;
            end
        endcase
    end

    logic [CH_W-1:0]  r_o_red, r_o_green, r_o_blue;
    logic [HUE_W-1:0] r_o_hue;

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r_o_red   <= s8_cr + r_s7_mn;
            r_o_green <= s8_cg + r_s7_mn;
            r_o_blue  <= s8_cb + r_s7_mn;
            r_o_hue   <= r_s7_hue;
        end
    end

    assign o_m_axis_tdata = {{(OUT_W - OUT_RAW){1'b0}}, r_o_hue, r_o_blue, r_o_green, r_o_red};

endmodule
